[rtl/coprq_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// coprq_pkg - shared types and codes of the cost ordered priority queue
// Operation and status codes, field widths and the command bundle that the
// control logic broadcasts to every cell of the chain.
// ----------------------------------------------------------------------------
package coprq_pkg;

    localparam int FUNC_W    = 3;
    localparam int IN_KEY_W  = 16;
    localparam int COST_W    = 24;
    localparam int STATUS_W  = 2;
    localparam int OCC_W     = 7;
    localparam int IN_DATA_W  = 48;   // 43 bits of fields, padded to bytes
    localparam int OUT_DATA_W = 56;   // 50 bits of fields, padded to bytes

    localparam logic [FUNC_W-1:0] OP_INSERT   = 3'd0;
    localparam logic [FUNC_W-1:0] OP_POP      = 3'd1;
    localparam logic [FUNC_W-1:0] OP_REMOVE   = 3'd2;
    localparam logic [FUNC_W-1:0] OP_CONTAINS = 3'd3;
    localparam logic [FUNC_W-1:0] OP_CLEAR    = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    // Command broadcast to all cells for one cycle
    typedef struct packed {
        logic cmp;   // latch cost and key compare flags
        logic ins;   // insert at the first cell whose cost is not lower
        logic pop;   // shift the whole chain towards the head
        logic rem;   // shift cells at and behind the first key match
        logic clr;   // invalidate every cell
    } t_cell_cmd;

endpackage
`default_nettype wire

[rtl/coprq_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// coprq_cell - one slot of the sorted chain
// Holds one entry, compares it against the broadcast word and moves entries
// to or from its neighbours on insert, pop and remove.
// ----------------------------------------------------------------------------
module coprq_cell
    import coprq_pkg::*;
#(
    parameter int KEY_WIDTH = 16
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  t_cell_cmd             i_cmd,
    input  wire  [KEY_WIDTH-1:0]  i_key,
    input  wire  [COST_W-1:0]     i_cost,
    input  wire                   i_left_ge,
    input  wire                   i_left_valid,
    input  wire  [KEY_WIDTH-1:0]  i_left_key,
    input  wire  [COST_W-1:0]     i_left_cost,
    input  wire                   i_right_valid,
    input  wire  [KEY_WIDTH-1:0]  i_right_key,
    input  wire  [COST_W-1:0]     i_right_cost,
    input  wire                   i_rem_sel,
    output logic                  o_valid,
    output logic [KEY_WIDTH-1:0]  o_key,
    output logic [COST_W-1:0]     o_cost,
    output logic                  o_ge,
    output logic                  o_eq
);

    logic                 r_valid;
    logic [KEY_WIDTH-1:0] r_key;
    logic [COST_W-1:0]    r_cost;
    logic                 r_ge;
    logic                 r_eq;

    // Compare flags; an empty slot counts as costlier than anything
    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp) begin
            r_ge <= !r_valid || (r_cost >= i_cost);
            r_eq <= r_valid && (r_key == i_key);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.clr) begin
            r_valid <= 1'b0;
        end else if (i_cmd.ins) begin
            if (i_left_ge) begin
                r_valid <= i_left_valid;
            end else if (r_ge) begin
                r_valid <= 1'b1;
            end
        end else if (i_cmd.pop || (i_cmd.rem && i_rem_sel)) begin
            r_valid <= i_right_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins) begin
            if (i_left_ge) begin
                r_key  <= i_left_key;
                r_cost <= i_left_cost;
            end else if (r_ge) begin
                r_key  <= i_key;
                r_cost <= i_cost;
            end
        end else if (i_cmd.pop || (i_cmd.rem && i_rem_sel)) begin
            r_key  <= i_right_key;
            r_cost <= i_right_cost;
        end
    end

    assign o_valid = r_valid;
    assign o_key   = r_key;
    assign o_cost  = r_cost;
    assign o_ge    = r_ge;
    assign o_eq    = r_eq;

endmodule
`default_nettype wire

[rtl/cost_ordered_priority_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cost_ordered_priority_queue - sorted priority queue in a chain of cells
// Keeps up to DEPTH entries in ascending cost order; insert, pop lowest,
// remove by key, contains and clear, one status word per operation.
//
//  channel   dir  word layout (lsb first)                             width
//  s_axis    in   func[2:0] item_key[18:3] item_cost[42:19]           48
//  m_axis    out  status[1:0] hit[2] out_key[18:3] out_cost[42:19]
//                 occupancy[49:43]                                    56
//
//  Each operation runs through capture, compare in every cell, then
//  shift the chain and load the result register. All cells work in
//  parallel in the compare stage and in the cell update.
//  The first-match search for remove is a log-depth prefix OR over the
//  registered match flags. Reset (synchronous, low) empties the chain.
//  A stalled result holds the update stage; a new word is taken while the
//  previous result still waits on m_axis.
// ----------------------------------------------------------------------------
module cost_ordered_priority_queue
    import coprq_pkg::*;
#(
    parameter int DEPTH     = 64,
    parameter int KEY_WIDTH = 16
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire  [IN_DATA_W-1:0]   s_axis_tdata,   // func, item_key, item_cost
    output logic                   m_axis_tvalid,
    input  wire                    m_axis_tready,
    output logic [OUT_DATA_W-1:0]  m_axis_tdata    // status, hit, out_key,
                                                   // out_cost, occupancy
);

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int LEVELS = $clog2(DEPTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0]            r_state;
    logic [1:0]            n_state;
    logic [FUNC_W-1:0]     r_func;
    logic [KEY_WIDTH-1:0]  r_key;
    logic [COST_W-1:0]     r_cost;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [OUT_DATA_W-1:0] n_out_data;

    // Chain wiring
    t_cell_cmd             cmd;
    logic [DEPTH-1:0]      c_valid;
    logic [DEPTH-1:0]      c_ge;
    logic [DEPTH-1:0]      c_eq;
    logic [KEY_WIDTH-1:0]  c_key  [DEPTH];
    logic [COST_W-1:0]     c_cost [DEPTH];
    logic [DEPTH-1:0]      pfx    [LEVELS+1];
    logic [DEPTH-1:0]      rem_sel;
    logic                  any_eq;

    logic                  accept;
    logic                  upd_go;
    logic                  full;
    logic                  empty;
    logic [31:0]           key_in_ext;
    logic [KEY_WIDTH+15:0] key_out_ext;
    logic [CNT_W+6:0]      occ_ext;
    logic [STATUS_W-1:0]   status;
    logic                  hit;
    logic [IN_KEY_W-1:0]   out_key;
    logic [COST_W-1:0]     out_cost;

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign upd_go        = (r_state == S_UPD) && (!r_out_valid || m_axis_tready);
    assign full          = (r_count == CNT_W'(DEPTH));
    assign empty         = (r_count == '0);

    // Keep only the low KEY_WIDTH bits of the incoming key
    assign key_in_ext = {16'd0, s_axis_tdata[18:3]};

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (accept) n_state = S_CMP;
            S_CMP:  n_state = S_UPD;
            S_UPD:  if (upd_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture the operation word
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func <= s_axis_tdata[2:0];
            r_key  <= key_in_ext[KEY_WIDTH-1:0];
            r_cost <= s_axis_tdata[42:19];
        end
    end

    // Prefix OR of match flags: a cell shifts on remove when it or any
    // cell ahead of it holds the key
    always_comb begin
        pfx[0] = c_eq;
        for (int l = 0; l < LEVELS; l++) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (i >= (1 << l)) begin
                    pfx[l+1][i] = pfx[l][i] | pfx[l][i - (1 << l)];
                end else begin
                    pfx[l+1][i] = pfx[l][i];
                end
            end
        end
    end

    assign rem_sel = pfx[LEVELS];
    assign any_eq  = rem_sel[DEPTH-1];

    // Broadcast command
    always_comb begin
        cmd     = '0;
        cmd.cmp = (r_state == S_CMP);
        if (upd_go) begin
            cmd.ins = (r_func == OP_INSERT) && !full;
            cmd.pop = (r_func == OP_POP) && !empty;
            cmd.rem = (r_func == OP_REMOVE) && any_eq;
            cmd.clr = (r_func == OP_CLEAR);
        end
    end

    // Count and result word
    assign key_out_ext = {16'd0, c_key[0]};

    always_comb begin
        n_count  = r_count;
        status   = ST_OK;
        hit      = 1'b0;
        out_key  = '0;
        out_cost = '0;
        case (r_func)
            OP_INSERT: begin
                if (full) status = ST_FULL;
                else      n_count = r_count + 1'b1;
            end
            OP_POP: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    n_count  = r_count - 1'b1;
                    out_key  = key_out_ext[IN_KEY_W-1:0];
                    out_cost = c_cost[0];
                end
            end
            OP_REMOVE: begin
                if (any_eq) n_count = r_count - 1'b1;
                else        status  = ST_NOT_FOUND;
            end
            OP_CONTAINS: hit = any_eq;
            OP_CLEAR:    n_count = '0;
            default: ;
        endcase
        occ_ext    = {7'd0, n_count};
        n_out_data = {6'd0, occ_ext[OCC_W-1:0], out_cost, out_key, hit, status};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (upd_go) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (upd_go) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Chain of cells: head at index 0 holds the lowest cost
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                 left_ge;
        logic                 left_valid;
        logic [KEY_WIDTH-1:0] left_key;
        logic [COST_W-1:0]    left_cost;
        logic                 right_valid;
        logic [KEY_WIDTH-1:0] right_key;
        logic [COST_W-1:0]    right_cost;

        if (g == 0) begin : g_head
            assign left_ge    = 1'b0;
            assign left_valid = 1'b0;
            assign left_key   = c_key[g];
            assign left_cost  = c_cost[g];
        end else begin : g_body
            assign left_ge    = c_ge[g-1];
            assign left_valid = c_valid[g-1];
            assign left_key   = c_key[g-1];
            assign left_cost  = c_cost[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign right_valid = 1'b0;
            assign right_key   = c_key[g];
            assign right_cost  = c_cost[g];
        end else begin : g_mid
            assign right_valid = c_valid[g+1];
            assign right_key   = c_key[g+1];
            assign right_cost  = c_cost[g+1];
        end

        coprq_cell #(
            .KEY_WIDTH (KEY_WIDTH)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (cmd),
            .i_key         (r_key),
            .i_cost        (r_cost),
            .i_left_ge     (left_ge),
            .i_left_valid  (left_valid),
            .i_left_key    (left_key),
            .i_left_cost   (left_cost),
            .i_right_valid (right_valid),
            .i_right_key   (right_key),
            .i_right_cost  (right_cost),
            .i_rem_sel     (rem_sel[g]),
            .o_valid       (c_valid[g]),
            .o_key         (c_key[g]),
            .o_cost        (c_cost[g]),
            .o_ge          (c_ge[g]),
            .o_eq          (c_eq[g])
        );
    end

    // Occupied cells always match the entry count
    a_count_matches_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(c_valid) == r_count)
        else $error("cell valid bits disagree with entry count");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    a_accept_to_compare: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_CMP))
        else $error("accepted word did not enter compare stage");

    a_empty_has_no_entries: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_data[1:0] == ST_EMPTY)) |-> (r_out_data[49:43] == '0))
        else $error("empty status with nonzero occupancy");

    a_head_valid_when_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> c_valid[0])
        else $error("head cell empty while queue holds entries");

endmodule
`default_nettype wire
